### hw/rtl/npf_pkg.sv
package npf_pkg;

	// default width of the signed start value
	localparam int DATA_WIDTH_DEF = 32;

	// width of the result field
	localparam int PRIME_W = 31;

	// status from the remainder unit to the sequencer
	typedef struct packed {
		logic done;
		logic zero;
	} rem_sts_t;

endpackage

### hw/rtl/npf_rem_unit.sv
module npf_rem_unit #(
	parameter int DIVIDEND_W = 32,
	parameter int DIVISOR_W  = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output npf_pkg::rem_sts_t     sts
);
	import npf_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic [DIVISOR_W:0]    rem_sub;
	logic                  fits;

	// shift in the next dividend bit and try one subtraction
	always_comb begin
		rem_sh  = {rem_q, num_q[DIVIDEND_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		fits    = (rem_sh >= {1'b0, den_q});
	end

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// advance the restoring division one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
		end
	end

	assign sts.done = done_q;
	assign sts.zero = (rem_q == '0);

endmodule

### hw/rtl/next_prime_finder.sv
// Next prime at or above a signed start value, by trial division with odd divisors.
// Start values of 2 or less give 2 with no divisor trial; otherwise each odd candidate up to
// the result gets up to sqrt(candidate)/2 divisor trials, each run bit-serially in the
// serial remainder unit.
// Throughput: one request at a time; in_stall stays high until the result is taken.
// Reset: arst_n clears the sequencer and handshake flags at once; no clearing pass.
module next_prime_finder #(
	parameter int DATA_WIDTH = npf_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [DATA_WIDTH-1:0] start_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [npf_pkg::PRIME_W-1:0] prime_found
);
	import npf_pkg::*;

	localparam int DIV_W = (DATA_WIDTH + 1) / 2 + 1;
	localparam int SQ_W  = DATA_WIDTH + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ODD,
		ST_TEST,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                state_q;
	logic                  start_q;
	logic [DATA_WIDTH-1:0] cand_q;
	logic [DIV_W-1:0]      div_q;
	logic [SQ_W-1:0]       sq_q;
	rem_sts_t              rem_sts;
	logic                  small_in;

	// start values that are negative, zero, one or two
	assign small_in = start_value[DATA_WIDTH-1] ||
		(start_value[DATA_WIDTH-2:0] <= (DATA_WIDTH-1)'(2));

	// sequence candidates and divisor trials
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= small_in ? ST_OUT : ST_ODD;
					end
				end
				ST_ODD: begin
					state_q <= cand_q[0] ? ST_TEST : ST_ODD;
				end
				ST_TEST: begin
					if (sq_q <= {1'b0, cand_q}) begin
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (rem_sts.done) begin
						state_q <= rem_sts.zero ? ST_ODD : ST_TEST;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold candidate, divisor and divisor square
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cand_q <= small_in ? DATA_WIDTH'(2) : start_value;
				end
			end
			ST_ODD: begin
				div_q <= DIV_W'(3);
				sq_q  <= SQ_W'(9);
				if (!cand_q[0]) begin
					cand_q <= cand_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (rem_sts.done) begin
					if (rem_sts.zero) begin
						cand_q <= cand_q + 1'b1;
					end else begin
						div_q <= div_q + DIV_W'(2);
						sq_q  <= sq_q + SQ_W'({div_q, 2'b00}) + SQ_W'(4);
					end
				end
			end
			default: begin
			end
		endcase
	end

	npf_rem_unit #(
		.DIVIDEND_W(DATA_WIDTH),
		.DIVISOR_W (DIV_W)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.dividend(cand_q),
		.divisor (div_q),
		.sts     (rem_sts)
	);

	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign prime_found = PRIME_W'(cand_q);

endmodule

### hw/rtl/npf_checker.sv
module npf_checker #(
	parameter int DATA_WIDTH = npf_pkg::DATA_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [npf_pkg::PRIME_W-1:0]  prime_found
);
	import npf_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(prime_found))
		else $error("stalled result changed");

	// a result is never below two
	a_min_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> prime_found >= PRIME_W'(2))
		else $error("result below two");

	// a result is two or odd
	a_odd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (prime_found == PRIME_W'(2)) || prime_found[0])
		else $error("even result above two");

	// an accepted request makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while not busy afterward");

	// no new request while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");

endmodule

bind next_prime_finder npf_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_npf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.prime_found(prime_found)
);

### bench/next_prime_finder_test.sv
module next_prime_finder_test;

	localparam int DW = npf_pkg::DATA_WIDTH_DEF;
	localparam int PW = npf_pkg::PRIME_W;
	localparam int CLK_HALF = 6;
	localparam int MAX_CYCLES = 10_000_000;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 50;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [DW-1:0] start_value;
	logic                 out_valid;
	logic                 out_stall;
	logic [PW-1:0]        prime_found;

	// primes still owed by the block, oldest first
	logic [PW-1:0] pending_primes[$];
	logic [PW-1:0] owed_prime;
	int            mismatch_count;
	int            cycle_count;
	int            send_idle_pct;
	int            recv_idle_pct;

	next_prime_finder u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_value (start_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.prime_found (prime_found)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// trial division over a widened candidate, so the square never wraps
	function automatic bit is_prime(longint unsigned cand);
		longint unsigned d;
		if (cand < 2)
			return 1'b0;
		if (cand == 2)
			return 1'b1;
		if (cand[0] == 1'b0)
			return 1'b0;
		for (d = 3; d * d <= cand; d += 2) begin
			if (cand % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// smallest prime at or above a signed start value, never below two
	function automatic logic [PW-1:0] next_prime_at_or_above(logic signed [DW-1:0] v);
		longint unsigned cand;
		if (v <= 2)
			return PW'(2);
		cand = longint'(v);
		while (!is_prime(cand))
			cand++;
		return cand[PW-1:0];
	endfunction

	// mostly cheap searches: negatives, tiny values, small and a few medium values
	function automatic logic signed [DW-1:0] random_start();
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			return {1'b1, (DW-1)'($urandom)};
		if (pick < 40)
			return DW'($urandom_range(3));
		if (pick < 90)
			return DW'($urandom_range(4095));
		return DW'($urandom_range(262143));
	endfunction

	task automatic note_mismatch(string what, logic [PW-1:0] exp_val, logic [PW-1:0] act_val);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("ERROR %0s: expected prime_found=%0d, got %0d", what, exp_val, act_val);
	endtask

	// send one request and hold it until taken
	task automatic send_start(logic signed [DW-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_primes.push_back(next_prime_at_or_above(v));
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
	endtask

	task automatic wait_all_results();
		while (pending_primes.size() != 0)
			@(posedge clk);
	endtask

	// negatives, zero, one and two all give two
	task automatic test_at_or_below_two();
		send_start(32'sh8000_0000);
		send_start(-32'sd1);
		send_start(-32'sd2);
		send_start(32'sd0);
		send_start(32'sd1);
		send_start(32'sd2);
	endtask

	// primes, evens, odd squares and a few gaps
	task automatic test_small_searches();
		send_start(32'sd3);
		send_start(32'sd4);
		send_start(32'sd8);
		send_start(32'sd9);
		send_start(32'sd25);
		send_start(32'sd49);
		send_start(32'sd120);
		send_start(32'sd1369);
		send_start(32'sd65521);
		send_start(32'sd65536);
		send_start(32'sd262140);
	endtask

	// largest signed input, itself prime: the longest divisor sweep
	task automatic test_top_of_range();
		send_start(32'sh7FFF_FFFF);
	endtask

	task automatic test_random_phase(int s_pct, int r_pct, int n);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (n)
			send_start(random_start());
	endtask

	// pause the sender until the block has drained, then resume
	task automatic test_drain_pause();
		repeat (3)
			send_start(random_start());
		drop_valid();
		wait_all_results();
		repeat (3)
			send_start(random_start());
	endtask

	// receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// compare each taken result with the oldest owed prime
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_primes.size() == 0) begin
				note_mismatch("unexpected result", '0, prime_found);
			end else begin
				owed_prime = pending_primes.pop_front();
				if (prime_found !== owed_prime)
					note_mismatch("prime_found", owed_prime, prime_found);
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		start_value = '0;
		out_stall = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		send_idle_pct = 29;
		recv_idle_pct = 82;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_at_or_below_two();
		test_small_searches();
		test_top_of_range();
		test_random_phase(29, 82, 35);
		test_random_phase(82, 29, 30);
		test_drain_pause();
		test_random_phase(0, 0, 30);
		drop_valid();

		// drain, then watch for stray results
		wait_all_results();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && pending_primes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
